### hw/rtl/bitmap_page_allocator_macros.svh
// Assertion helpers for bpa_ctrl; they compile away for synthesis.
`ifndef BITMAP_PAGE_ALLOCATOR_MACROS_SVH
`define BITMAP_PAGE_ALLOCATOR_MACROS_SVH

`ifndef SYNTHESIS
`define BPA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define BPA_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define BPA_ASSERT_IMP(lbl, ante, cons)
`define BPA_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

### hw/rtl/bpa_pkg.sv
package bpa_pkg;

    localparam int BPA_PAGES      = 4096;
    localparam int BPA_PAGE_SHIFT = 12;
    localparam int WORD_BITS      = 64;
    localparam int ADDR_W         = 24;
    localparam int CNT_OUT_W      = 13;
    localparam int BASE_W         = 12;

    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_RELEASE = 2'd1,
        OP_MARK    = 2'd2,
        OP_NONE    = 2'd3
    } bpa_op_t;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_NONE_FREE    = 3'd1,
        ST_MISALIGNED   = 3'd2,
        ST_NOT_USABLE   = 3'd3,
        ST_RESERVED     = 3'd4,
        ST_ALREADY_FREE = 3'd5
    } bpa_status_t;

    typedef enum logic [0:0] {
        CFG_RSV_BASE  = 1'b0,
        CFG_RSV_COUNT = 1'b1
    } bpa_cfg_idx_t;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_SCAN,
        S_EXEC,
        S_DONE
    } bpa_state_t;

    typedef struct packed {
        logic [ADDR_W-1:0]    addr;
        logic [2:0]           status;
        logic [CNT_OUT_W-1:0] free_cnt;
        logic [CNT_OUT_W-1:0] total_cnt;
    } bpa_result_t;

    // lowest set bit: {found, index}
    function automatic logic [6:0] bpa_lowest(input logic [WORD_BITS-1:0] v);
        logic [6:0] r;
        r = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                r = {1'b1, 6'(i)};
            end
        end
        return r;
    endfunction

endpackage

### hw/rtl/bpa_if.sv
interface bpa_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [23:0] page_address;

    modport source (output valid, operation, page_address, input ready);
    modport sink   (input valid, operation, page_address, output ready);
endinterface

interface bpa_rsp_if;
    logic        valid;
    logic        ready;
    logic [23:0] result_address;
    logic [2:0]  status;
    logic [12:0] free_count;
    logic [12:0] total_count;

    modport source (output valid, result_address, status, free_count, total_count,
                    input ready);
    modport sink   (input valid, result_address, status, free_count, total_count,
                    output ready);
endinterface

### hw/rtl/bpa_map_ram.sv
module bpa_map_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int DW    = 128
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/bpa_ctrl.sv
`include "bitmap_page_allocator_macros.svh"

module bpa_ctrl #(
    parameter int PAGES      = bpa_pkg::BPA_PAGES,
    parameter int PAGE_SHIFT = bpa_pkg::BPA_PAGE_SHIFT,
    parameter int NW         = (PAGES + 63) / 64,
    parameter int WIW        = (NW > 1) ? $clog2(NW) : 1
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   in_op,
    input  logic [23:0]                  in_addr,
    input  logic [bpa_pkg::BASE_W-1:0]   rsv_base,
    input  logic [12:0]                  rsv_count,
    output logic                         res_valid,
    input  logic                         res_ready,
    output bpa_pkg::bpa_result_t         res,
    output logic                         ram_we,
    output logic [WIW-1:0]               ram_waddr,
    output logic [127:0]                 ram_wdata,
    output logic [WIW-1:0]               ram_raddr,
    input  logic [127:0]                 ram_rdata
);
    import bpa_pkg::*;

    localparam int CW  = $clog2(PAGES + 1);
    localparam int PFW = ADDR_W - PAGE_SHIFT;

    bpa_state_t          state_reg, state_next;
    logic [1:0]          op_reg, op_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic [WIW-1:0]      ri_reg, ri_next;
    logic                rph_reg, rph_next;
    logic [CW-1:0]       sp_reg, sp_next;
    logic [CW-1:0]       free_reg, free_next;
    logic [CW-1:0]       total_reg, total_next;
    logic [WIW-1:0]      init_reg, init_next;
    bpa_result_t         res_reg, res_next;

    logic [CW-1:0]       sp_eff;
    logic [WIW-1:0]      sw;
    logic [5:0]          sb;
    logic [WORD_BITS-1:0] alloc_w, usable_w, mask, free_w;
    logic [6:0]          low;
    logic [CW-1:0]       fpage;
    logic [PFW-1:0]      pfull;
    logic [CW-1:0]       pg;
    logic [5:0]          pb;
    logic                misal, in_range, rsv;

    assign sp_eff   = (32'(sp_reg) >= 32'(PAGES)) ? '0 : sp_reg;
    assign sw       = WIW'(sp_eff >> 6);
    assign sb       = 6'(sp_eff);
    assign alloc_w  = ram_rdata[WORD_BITS-1:0];
    assign usable_w = ram_rdata[2*WORD_BITS-1:WORD_BITS];

    always_comb
    begin
        mask = '1;
        if (!rph_reg && ri_reg == sw)
        begin
            mask = {WORD_BITS{1'b1}} << sb;
        end
        else if (rph_reg && ri_reg == sw)
        begin
            mask = ~({WORD_BITS{1'b1}} << sb);
        end
    end

    assign free_w = ~alloc_w & mask;
    assign low    = bpa_lowest(free_w);
    assign fpage  = CW'({ri_reg, low[5:0]});

    assign pfull    = addr_reg[ADDR_W-1:PAGE_SHIFT];
    assign misal    = |addr_reg[PAGE_SHIFT-1:0];
    assign in_range = 32'(pfull) < 32'(PAGES);
    assign pg       = CW'(pfull);
    assign pb       = 6'(pg);
    assign rsv      = (32'(pg) >= 32'(rsv_base)) &&
                      ((32'(pg) - 32'(rsv_base)) < 32'(rsv_count));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            sp_reg    <= '0;
            free_reg  <= '0;
            total_reg <= '0;
            init_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            sp_reg    <= sp_next;
            free_reg  <= free_next;
            total_reg <= total_next;
            init_reg  <= init_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        addr_reg <= addr_next;
        ri_reg   <= ri_next;
        rph_reg  <= rph_next;
        res_reg  <= res_next;
    end

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        addr_next  = addr_reg;
        ri_next    = ri_reg;
        rph_next   = rph_reg;
        sp_next    = sp_reg;
        free_next  = free_reg;
        total_next = total_reg;
        init_next  = init_reg;
        res_next   = res_reg;
        in_ready   = 1'b0;
        res_valid  = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = ri_reg;
        ram_wdata  = ram_rdata;
        ram_raddr  = ri_reg;

        case (state_reg)
            S_INIT:
            begin
                // clearing pass: nothing usable, everything allocated
                ram_we    = 1'b1;
                ram_waddr = init_reg;
                ram_wdata = {{WORD_BITS{1'b0}}, {WORD_BITS{1'b1}}};
                init_next = init_reg + 1'b1;
                if (32'(init_reg) == NW - 1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready  = 1'b1;
                ram_raddr = (in_op == OP_ALLOC) ? sw :
                            WIW'(in_addr[ADDR_W-1:PAGE_SHIFT] >> 6);
                if (in_valid)
                begin
                    op_next   = in_op;
                    addr_next = in_addr;
                    ri_next   = sw;
                    rph_next  = 1'b0;
                    case (in_op)
                        OP_ALLOC:   state_next = S_SCAN;
                        OP_RELEASE,
                        OP_MARK:    state_next = S_EXEC;
                        default:
                        begin
                            res_next.addr   = '0;
                            res_next.status = ST_OK;
                            state_next      = S_DONE;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                // ri_reg tags the word now on ram_rdata; the next word is fetched meanwhile
                if (32'(ri_reg) == NW - 1)
                begin
                    ri_next  = '0;
                    rph_next = 1'b1;
                end
                else
                begin
                    ri_next = ri_reg + 1'b1;
                end
                ram_raddr = ri_next;
                if (low[6])
                begin
                    ram_we    = 1'b1;
                    ram_wdata = {usable_w, alloc_w | (WORD_BITS'(1) << low[5:0])};
                    if (free_reg != '0)
                    begin
                        free_next = free_reg - 1'b1;
                    end
                    sp_next         = fpage + 1'b1;
                    res_next.addr   = ADDR_W'(32'(fpage) << PAGE_SHIFT);
                    res_next.status = ST_OK;
                    state_next      = S_DONE;
                end
                else if (rph_reg && ri_reg == sw)
                begin
                    res_next.addr   = '0;
                    res_next.status = ST_NONE_FREE;
                    state_next      = S_DONE;
                end
            end
            S_EXEC:
            begin
                ram_waddr       = WIW'(pg >> 6);
                res_next.addr   = '0;
                res_next.status = ST_OK;
                state_next      = S_DONE;
                if (misal)
                begin
                    res_next.status = ST_MISALIGNED;
                end
                else if (op_reg == OP_RELEASE)
                begin
                    if (!in_range || !usable_w[pb])
                    begin
                        res_next.status = ST_NOT_USABLE;
                    end
                    else if (rsv)
                    begin
                        res_next.status = ST_RESERVED;
                    end
                    else if (!alloc_w[pb])
                    begin
                        res_next.status = ST_ALREADY_FREE;
                    end
                    else
                    begin
                        ram_we    = 1'b1;
                        ram_wdata = {usable_w, alloc_w & ~(WORD_BITS'(1) << pb)};
                        free_next = free_reg + 1'b1;
                        if (pg < sp_reg)
                        begin
                            sp_next = pg;
                        end
                    end
                end
                else if (!in_range)
                begin
                    res_next.status = ST_NOT_USABLE;
                end
                else if (!usable_w[pb])
                begin
                    ram_we     = 1'b1;
                    total_next = total_reg + 1'b1;
                    if (!rsv && alloc_w[pb])
                    begin
                        ram_wdata = {usable_w | (WORD_BITS'(1) << pb),
                                     alloc_w & ~(WORD_BITS'(1) << pb)};
                        free_next = free_reg + 1'b1;
                    end
                    else
                    begin
                        ram_wdata = {usable_w | (WORD_BITS'(1) << pb), alloc_w};
                    end
                end
            end
            S_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res           = res_reg;
        res.free_cnt  = CNT_OUT_W'(free_reg);
        res.total_cnt = CNT_OUT_W'(total_reg);
    end

    `BPA_ASSERT_IMP(a_free_le_total, 1'b1, free_reg <= total_reg)
    `BPA_ASSERT_IMP(a_sp_bound, 1'b1, 32'(sp_reg) <= 32'(PAGES))
    `BPA_ASSERT_NXT(a_total_mono, 1'b1, total_reg >= $past(total_reg))

endmodule

### hw/rtl/bitmap_page_allocator.sv
// Bitmap page frame allocator, next-fit, one allocated and one usable bit per page.
// Channels: in_ch takes items {operation, page_address}; out_ch returns one item
// {result_address, status, free_count, total_count} per input item, valid/ready.
// Config: cfg_we with cfg_index 0 writes the reserved base page, index 1 the
// reserved page count; the user must write them only while the block is idle,
// and the block itself does not enforce this.
// Allocate scans one 64-page bitmap word per cycle from the memory and visits
// at most NW + 1 words, NW being PAGES/64 rounded up.
// One item is in work at a time; the next is taken once the result has moved
// into the output register.
// Reset: a clearing pass writes every bitmap word with all pages allocated and
// none usable; in_ch.ready stays low during it.
// If out_ch stalls, the result waits in the output register and the next item
// may finish its work; it then holds until the register frees up.
module bitmap_page_allocator #(
    parameter int PAGES      = bpa_pkg::BPA_PAGES,
    parameter int PAGE_SHIFT = bpa_pkg::BPA_PAGE_SHIFT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    bpa_req_if.sink              in_ch,
    bpa_rsp_if.source            out_ch,
    input  logic                 cfg_we,
    input  logic [0:0]           cfg_index,
    input  logic [12:0]          cfg_wdata
);
    import bpa_pkg::*;

    localparam int NW  = (PAGES + 63) / 64;
    localparam int WIW = (NW > 1) ? $clog2(NW) : 1;

    logic [BASE_W-1:0] base_reg;
    logic [12:0]       cnt_reg;
    logic              out_valid_reg;
    bpa_result_t       out_reg;

    logic              res_valid, res_ready;
    bpa_result_t       res;
    logic              ram_we;
    logic [WIW-1:0]    ram_waddr, ram_raddr;
    logic [127:0]      ram_wdata, ram_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= '0;
            cnt_reg  <= 13'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_RSV_BASE:  base_reg <= cfg_wdata[BASE_W-1:0];
                CFG_RSV_COUNT: cnt_reg  <= cfg_wdata;
                default:       cnt_reg  <= cnt_reg;
            endcase
        end
    end

    assign res_ready = !out_valid_reg || out_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.result_address = out_reg.addr;
    assign out_ch.status         = out_reg.status;
    assign out_ch.free_count     = out_reg.free_cnt;
    assign out_ch.total_count    = out_reg.total_cnt;

    bpa_ctrl #(
        .PAGES      (PAGES),
        .PAGE_SHIFT (PAGE_SHIFT),
        .NW         (NW),
        .WIW        (WIW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .in_op     (in_ch.operation),
        .in_addr   (in_ch.page_address),
        .rsv_base  (base_reg),
        .rsv_count (cnt_reg),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    bpa_map_ram #(
        .DEPTH (NW),
        .AW    (WIW),
        .DW    (128)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

### verif/bitmap_page_allocator_test.sv
`timescale 1ns / 100ps

module bitmap_page_allocator_test;
    import bpa_pkg::*;

    localparam int NPAGES = BPA_PAGES;
    localparam int RANDOM_PER_PHASE = 235;

    typedef struct {
        bpa_op_t           op;
        logic [ADDR_W-1:0] addr;
        bit                typed;
        logic [ADDR_W-1:0] want_addr;
        bpa_status_t       want_status;
    } page_req_row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [0:0] cfg_index;
    logic [12:0] cfg_wdata;

    bpa_req_if in_ch();
    bpa_rsp_if out_ch();

    bitmap_page_allocator DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // shadow of the allocator state
    bit page_taken [NPAGES];
    bit page_usable [NPAGES];
    int next_fit_ptr;
    int unused_pages;
    int usable_pages;
    int rsv_base;
    int rsv_count;

    bpa_result_t pending_results[$];
    int errors;
    page_req_row_t directed_rows[$];

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #1 clk = 1'b1;
            #1 clk = 1'b0;
        end
    end

    initial
    begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        errors++;
    endtask

    function automatic bit page_reserved(input int pg);
        return pg >= rsv_base && (pg - rsv_base) < rsv_count;
    endfunction

    function automatic bpa_result_t predict_page_op(input bpa_op_t op,
                                                    input logic [ADDR_W-1:0] a);
        bpa_result_t r;
        int pg;
        int p;
        r = '0;
        r.status = ST_OK;
        pg = int'(a[ADDR_W-1:BPA_PAGE_SHIFT]);
        case (op)
            OP_ALLOC:
            begin
                pg = -1;
                for (int i = 0; i < NPAGES; i++)
                begin
                    p = (next_fit_ptr + i) % NPAGES;
                    if (pg < 0 && !page_taken[p])
                        pg = p;
                end
                if (pg < 0)
                    r.status = ST_NONE_FREE;
                else
                begin
                    page_taken[pg] = 1'b1;
                    if (unused_pages > 0)
                        unused_pages--;
                    next_fit_ptr = pg + 1;
                    r.addr = ADDR_W'(pg << BPA_PAGE_SHIFT);
                end
            end
            OP_RELEASE:
            begin
                if (a[BPA_PAGE_SHIFT-1:0] != 0)
                    r.status = ST_MISALIGNED;
                else if (!page_usable[pg])
                    r.status = ST_NOT_USABLE;
                else if (page_reserved(pg))
                    r.status = ST_RESERVED;
                else if (!page_taken[pg])
                    r.status = ST_ALREADY_FREE;
                else
                begin
                    page_taken[pg] = 1'b0;
                    unused_pages++;
                    if (pg < next_fit_ptr)
                        next_fit_ptr = pg;
                end
            end
            OP_MARK:
            begin
                if (a[BPA_PAGE_SHIFT-1:0] != 0)
                    r.status = ST_MISALIGNED;
                else if (!page_usable[pg])
                begin
                    page_usable[pg] = 1'b1;
                    usable_pages++;
                    if (!page_reserved(pg) && page_taken[pg])
                    begin
                        page_taken[pg] = 1'b0;
                        unused_pages++;
                    end
                end
            end
            default: ;
        endcase
        r.free_cnt = CNT_OUT_W'(unused_pages);
        r.total_cnt = CNT_OUT_W'(usable_pages);
        return r;
    endfunction

    task automatic write_reg(input bpa_cfg_idx_t idx, input int value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= 13'(value);
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_RSV_BASE)
            rsv_base = value & 12'hFFF;
        else
            rsv_count = value & 13'h1FFF;
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0)
            @(posedge clk);
        // allow an in-flight allocate scan to settle
        repeat (80) @(posedge clk);
    endtask

    function automatic int pick_gap();
        if ($urandom_range(0, 3) == 0)
            return 0;
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(10, 30);
        return $urandom_range(0, 3);
    endfunction

    // gap of zero keeps valid high across back-to-back items
    task automatic send_item(input bpa_op_t op, input logic [ADDR_W-1:0] a,
                             input bit typed, input logic [ADDR_W-1:0] want_addr,
                             input bpa_status_t want_status);
        int gap;
        bit taken;
        bpa_result_t e;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.operation <= op;
        in_ch.page_address <= a;
        forever
        begin
            @(negedge clk);
            taken = in_ch.ready;
            @(posedge clk);
            if (taken)
                break;
        end
        e = predict_page_op(op, a);
        if (typed)
        begin
            e.addr = want_addr;
            e.status = want_status;
        end
        pending_results.push_back(e);
    endtask

    task automatic send_random_item();
        int r;
        int pg;
        bpa_op_t op;
        logic [ADDR_W-1:0] a;
        r = $urandom_range(0, 99);
        if (r < 35)
            op = OP_ALLOC;
        else if (r < 65)
            op = OP_RELEASE;
        else if (r < 93)
            op = OP_MARK;
        else
            op = OP_NONE;
        r = $urandom_range(0, 99);
        if (r < 8)
            a = ADDR_W'($urandom);
        else
        begin
            if (r < 45)
                pg = $urandom_range(0, 40);
            else if (r < 80)
                pg = NPAGES - 1 - $urandom_range(0, 40);
            else
                pg = $urandom_range(0, NPAGES - 1);
            a = ADDR_W'(pg << BPA_PAGE_SHIFT);
        end
        send_item(op, a, 1'b0, '0, ST_OK);
    endtask

    // ready: runs of high and low, mostly short stalls
    initial
    begin
        int n;
        out_ch.ready = 1'b0;
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 2) != 0)
            begin
                out_ch.ready <= 1'b1;
                n = $urandom_range(1, 20);
            end
            else
            begin
                out_ch.ready <= 1'b0;
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                : $urandom_range(1, 3);
            end
            repeat (n) @(posedge clk);
        end
    end

    always @(negedge clk)
    begin
        bpa_result_t e;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result item with none expected");
            else
            begin
                e = pending_results.pop_front();
                if (out_ch.result_address !== e.addr)
                    report_mismatch($sformatf("result_address %h, expected %h",
                                              out_ch.result_address, e.addr));
                if (out_ch.status !== e.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              out_ch.status, e.status));
                if (out_ch.free_count !== e.free_cnt)
                    report_mismatch($sformatf("free_count %0d, expected %0d",
                                              out_ch.free_count, e.free_cnt));
                if (out_ch.total_count !== e.total_cnt)
                    report_mismatch($sformatf("total_count %0d, expected %0d",
                                              out_ch.total_count, e.total_cnt));
            end
        end
    end

    initial
    begin
        page_req_row_t row;
        errors = 0;
        for (int i = 0; i < NPAGES; i++)
        begin
            page_taken[i] = 1'b1;
            page_usable[i] = 1'b0;
        end
        next_fit_ptr = 0;
        unused_pages = 0;
        usable_pages = 0;
        rsv_base = 0;
        rsv_count = 1;

        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        in_ch.valid = 1'b0;
        in_ch.operation = OP_NONE;
        in_ch.page_address = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // hold off until the bitmap clearing pass is over
        do @(negedge clk); while (!in_ch.ready);
        @(posedge clk);
        write_reg(CFG_RSV_BASE, 0);
        write_reg(CFG_RSV_COUNT, 1);

        directed_rows = '{
            '{OP_ALLOC,   24'h000000, 1'b1, 24'h000000, ST_NONE_FREE},
            '{OP_RELEASE, 24'h000001, 1'b1, 24'h000000, ST_MISALIGNED},
            '{OP_MARK,    24'h000800, 1'b1, 24'h000000, ST_MISALIGNED},
            '{OP_MARK,    24'hFFF000, 1'b1, 24'h000000, ST_OK},
            '{OP_MARK,    24'h000000, 1'b1, 24'h000000, ST_OK},
            '{OP_RELEASE, 24'h000000, 1'b1, 24'h000000, ST_RESERVED},
            '{OP_ALLOC,   24'hFFFFFF, 1'b1, 24'hFFF000, ST_OK},
            '{OP_ALLOC,   24'h000000, 1'b1, 24'h000000, ST_NONE_FREE},
            '{OP_RELEASE, 24'hFFF000, 1'b1, 24'h000000, ST_OK},
            '{OP_RELEASE, 24'hFFF000, 1'b1, 24'h000000, ST_ALREADY_FREE},
            '{OP_RELEASE, 24'h001000, 1'b1, 24'h000000, ST_NOT_USABLE},
            '{OP_RELEASE, 24'hFFFFFF, 1'b1, 24'h000000, ST_MISALIGNED},
            '{OP_NONE,    24'hABCDEF, 1'b1, 24'h000000, ST_OK},
            '{OP_MARK,    24'hFFF000, 1'b1, 24'h000000, ST_OK},
            '{OP_MARK,    24'h001000, 1'b0, 24'h000000, ST_OK},
            '{OP_MARK,    24'h002000, 1'b0, 24'h000000, ST_OK},
            '{OP_MARK,    24'h800000, 1'b0, 24'h000000, ST_OK},
            '{OP_ALLOC,   24'h000000, 1'b0, 24'h000000, ST_OK},
            '{OP_ALLOC,   24'h000000, 1'b0, 24'h000000, ST_OK},
            '{OP_RELEASE, 24'h001000, 1'b0, 24'h000000, ST_OK},
            '{OP_ALLOC,   24'h000000, 1'b0, 24'h000000, ST_OK},
            '{OP_ALLOC,   24'h000000, 1'b0, 24'h000000, ST_OK},
            '{OP_ALLOC,   24'h000000, 1'b0, 24'h000000, ST_OK}
        };
        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            send_item(row.op, row.addr, row.typed, row.want_addr, row.want_status);
        end

        for (int phase = 0; phase < 4; phase++)
        begin
            in_ch.valid <= 1'b0;
            wait_drained();
            case (phase)
                0:
                begin
                    write_reg(CFG_RSV_BASE, 0);
                    write_reg(CFG_RSV_COUNT, 0);
                end
                1:
                begin
                    write_reg(CFG_RSV_BASE, $urandom_range(0, 40));
                    write_reg(CFG_RSV_COUNT, $urandom_range(1, 20));
                end
                2:
                begin
                    write_reg(CFG_RSV_BASE, 4095);
                    write_reg(CFG_RSV_COUNT, 4096);
                end
                default:
                begin
                    write_reg(CFG_RSV_BASE, 0);
                    write_reg(CFG_RSV_COUNT, 4096);
                end
            endcase
            repeat (RANDOM_PER_PHASE) send_random_item();
        end
        in_ch.valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
